// ===== rtl/core/iqrs_pkg.sv =====
// Shared types and constants of the integer quadratic root solver.
// Has no dependencies; every other file of the block depends on it.
package iqrs_pkg;

  // Default coefficient width of the solver.
  localparam int unsigned COEF_WIDTH_DEF = 16;

  // Result field widths, fixed by the result word format.
  localparam int unsigned ROOT_WIDTH = 17;
  localparam int unsigned IMAG_WIDTH = 16;
  localparam int unsigned CODE_WIDTH = 3;

  // Saturation limits of the result fields.
  localparam longint ROOT_MAX     = 65535;
  localparam longint ROOT_NEG_MAG = 65536;
  localparam longint IMAG_MAX     = 65535;

  typedef enum logic [CODE_WIDTH-1:0] {
    CASE_LINEAR   = 3'd0,
    CASE_TWO_REAL = 3'd1,
    CASE_DOUBLE   = 3'd2,
    CASE_COMPLEX  = 3'd3,
    CASE_DEGEN    = 3'd4
  } case_e;

endpackage

// ===== rtl/core/iqrs_if.sv =====
// Valid/ready channels of the integer quadratic root solver.
// Depends on iqrs_pkg for the default coefficient width and the result field widths.
interface iqrs_coef_if #(
  parameter int unsigned COEF_WIDTH = iqrs_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_quad;
  logic signed [COEF_WIDTH-1:0] coef_lin;
  logic signed [COEF_WIDTH-1:0] coef_const;

  modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink   (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

interface iqrs_root_if;
  logic                                    valid;
  logic                                    ready;
  logic [iqrs_pkg::CODE_WIDTH-1:0]         case_code;
  logic signed [iqrs_pkg::ROOT_WIDTH-1:0]  root_one;
  logic signed [iqrs_pkg::ROOT_WIDTH-1:0]  root_two;
  logic [iqrs_pkg::IMAG_WIDTH-1:0]         imag_part;

  modport source (output valid, case_code, root_one, root_two, imag_part, input ready);
  modport sink   (input valid, case_code, root_one, root_two, imag_part, output ready);
endinterface

// ===== rtl/core/integer_quadratic_root_solver.sv =====
// Top level of the integer quadratic root solver: a fully pipelined datapath.
// Depends on iqrs_pkg and on the channel interfaces in iqrs_if.sv.

// The solver takes one coefficient word (a, b, c) per clock while the output
// is not stalled and returns one result word per coefficient word, in order.
// Throughput is one word per cycle under the same condition. The pipeline
// depth is set by the square root unit, which resolves one root bit per stage
// over COEF_WIDTH + 2 stages, and by the restoring divider, which resolves one
// quotient bit per stage over COEF_WIDTH + 3 stages. All stages advance
// together whenever the output register is empty or being drained, so a
// stalled consumer freezes the whole pipeline without losing or duplicating a
// word. Every root is the exact real value truncated toward zero, including
// irrational roots, and results that do not fit the 17-bit root or 16-bit
// imaginary fields saturate.
module integer_quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = iqrs_pkg::COEF_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  iqrs_coef_if.sink        coef_i,
  iqrs_root_if.source      res_o
);
  import iqrs_pkg::*;

  localparam int unsigned W    = COEF_WIDTH;
  localparam int unsigned PW   = W + 1;       // signed numerator base p
  localparam int unsigned DW   = 2 * W + 3;   // signed discriminant
  localparam int unsigned RW   = 2 * W + 4;   // radicand, even width
  localparam int unsigned SQN  = W + 2;       // root bits and sqrt stages
  localparam int unsigned RMW  = SQN + 3;     // sqrt partial remainder
  localparam int unsigned NNW  = W + 4;       // signed surd numerator
  localparam int unsigned NW   = W + 3;       // numerator magnitude, div stages
  localparam int unsigned RDW  = W + 2;       // divider partial remainder
  localparam int unsigned SW   = NW + 18;     // compare width for saturation
  localparam int unsigned LANES = 3;

  typedef struct packed {
    case_e                  code;
    logic signed [PW-1:0]   p;
    logic [W:0]             d;
    logic                   kpos;
  } sq_info_t;

  typedef struct packed {
    case_e      code;
    logic       neg1;
    logic       neg2;
    logic [W:0] d;
  } dv_info_t;

  // The whole pipeline moves when the output register can take a new word.
  logic en;
  assign en           = !res_o.valid || res_o.ready;
  assign coef_i.ready = en;

  // Stage 1: the two products of the discriminant, plus the divisor and the
  // base numerator. For a linear equation -c/b is rewritten as p/|b| with the
  // sign of b folded into p; otherwise p/d = -b/(2a) with d made positive.
  logic                   s1_vld_q;
  logic signed [2*W-1:0]  s1_bb_q, s1_ac_q;
  logic signed [PW-1:0]   s1_p_q;
  logic [W:0]             s1_d_q;
  logic                   s1_az_q, s1_bz_q, s1_kpos_q;

  logic signed [PW-1:0] a_x, b_x, c_x;
  logic signed [PW-1:0] p1_d;
  logic [W:0]           d1_d, abs_a, abs_b;
  logic                 az, bz;

  always_comb begin
    a_x   = {coef_i.coef_quad[W-1], coef_i.coef_quad};
    b_x   = {coef_i.coef_lin[W-1], coef_i.coef_lin};
    c_x   = {coef_i.coef_const[W-1], coef_i.coef_const};
    abs_a = a_x[PW-1] ? unsigned'(-a_x) : unsigned'(a_x);
    abs_b = b_x[PW-1] ? unsigned'(-b_x) : unsigned'(b_x);
    az    = (coef_i.coef_quad == '0);
    bz    = (coef_i.coef_lin == '0);
    if (az) begin
      p1_d = b_x[PW-1] ? c_x : -c_x;
      d1_d = abs_b;
    end else begin
      p1_d = a_x[PW-1] ? b_x : -b_x;
      d1_d = {abs_a[W-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bb_q   <= coef_i.coef_lin * coef_i.coef_lin;
      s1_ac_q   <= coef_i.coef_quad * coef_i.coef_const;
      s1_p_q    <= p1_d;
      s1_d_q    <= d1_d;
      s1_az_q   <= az;
      s1_bz_q   <= bz;
      s1_kpos_q <= !coef_i.coef_quad[W-1];
    end
  end

  // Stage 2 and the square root stages. Entry 0 holds the discriminant
  // magnitude and the case; each later entry has one more root bit.
  logic [RW-1:0]   sq_rad_q [SQN+1];
  logic [RW-1:0]   sq_rad_d [SQN+1];
  logic [RMW-1:0]  sq_rem_q [SQN+1];
  logic [RMW-1:0]  sq_rem_d [SQN+1];
  logic [SQN-1:0]  sq_root_q [SQN+1];
  logic [SQN-1:0]  sq_root_d [SQN+1];
  sq_info_t        sq_info_q [SQN+1];
  sq_info_t        sq_info_d [SQN+1];
  logic [SQN:0]    sq_vld_q;

  logic signed [DW-1:0] disc;
  logic [RMW-1:0]       rem_sh  [SQN];
  logic [RMW-1:0]       trial   [SQN];

  always_comb begin
    disc = {{3{s1_bb_q[2*W-1]}}, s1_bb_q} - {s1_ac_q[2*W-1], s1_ac_q, 2'b00};
    sq_info_d[0].p    = s1_p_q;
    sq_info_d[0].d    = s1_d_q;
    sq_info_d[0].kpos = s1_kpos_q;
    if (s1_az_q && s1_bz_q) begin
      sq_info_d[0].code = CASE_DEGEN;
    end else if (s1_az_q) begin
      sq_info_d[0].code = CASE_LINEAR;
    end else if (disc == '0) begin
      sq_info_d[0].code = CASE_DOUBLE;
    end else if (!disc[DW-1]) begin
      sq_info_d[0].code = CASE_TWO_REAL;
    end else begin
      sq_info_d[0].code = CASE_COMPLEX;
    end
    sq_rad_d[0]  = disc[DW-1] ? RW'(unsigned'(-disc)) : RW'(unsigned'(disc));
    sq_rem_d[0]  = '0;
    sq_root_d[0] = '0;
    for (int j = 0; j < SQN; j++) begin
      rem_sh[j] = {sq_rem_q[j][RMW-3:0], sq_rad_q[j][RW-1:RW-2]};
      trial[j]  = {1'b0, sq_root_q[j], 2'b01};
      sq_rad_d[j+1]  = {sq_rad_q[j][RW-3:0], 2'b00};
      sq_info_d[j+1] = sq_info_q[j];
      if (rem_sh[j] >= trial[j]) begin
        sq_rem_d[j+1]  = rem_sh[j] - trial[j];
        sq_root_d[j+1] = {sq_root_q[j][SQN-2:0], 1'b1};
      end else begin
        sq_rem_d[j+1]  = rem_sh[j];
        sq_root_d[j+1] = {sq_root_q[j][SQN-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j <= SQN; j++) begin
        sq_rad_q[j]  <= sq_rad_d[j];
        sq_rem_q[j]  <= sq_rem_d[j];
        sq_root_q[j] <= sq_root_d[j];
        sq_info_q[j] <= sq_info_d[j];
      end
    end
  end

  // Preparation: each value is (n + f) / d with integer n and 0 <= f < 1, and
  // f is nonzero exactly when the discriminant is not a perfect square. The
  // truncated quotient is then a plain unsigned division of a magnitude.
  logic [SQN-1:0]        s_root;
  logic                  exact, frac;
  logic signed [NNW-1:0] pe, se, n_plus, n_minus, n1, n2;
  logic [NW-1:0]         dv_num_d [LANES][NW+1];
  logic [NW-1:0]         dv_num_q [LANES][NW+1];
  logic [RDW-1:0]        dv_rem_d [LANES][NW+1];
  logic [RDW-1:0]        dv_rem_q [LANES][NW+1];
  dv_info_t              dv_info_d [NW+1];
  dv_info_t              dv_info_q [NW+1];
  logic [NW:0]           dv_vld_q;
  logic [RDW-1:0]        dv_sh [LANES][NW];
  logic                  is_two, is_cplx;

  always_comb begin
    s_root  = sq_root_q[SQN];
    exact   = (sq_rem_q[SQN] == '0);
    is_two  = (sq_info_q[SQN].code == CASE_TWO_REAL);
    is_cplx = (sq_info_q[SQN].code == CASE_COMPLEX);
    frac    = is_two && !exact;
    pe      = NNW'(sq_info_q[SQN].p);
    se      = signed'(NNW'(s_root));
    n_plus  = pe + se;
    n_minus = pe - se - (exact ? NNW'(0) : NNW'(1));
    if (is_two) begin
      n1 = sq_info_q[SQN].kpos ? n_plus : n_minus;
      n2 = sq_info_q[SQN].kpos ? n_minus : n_plus;
    end else if (sq_info_q[SQN].code == CASE_DEGEN) begin
      // A degenerate equation has no root, so both numerators are zero.
      n1 = '0;
      n2 = '0;
    end else begin
      n1 = pe;
      n2 = '0;
    end
    dv_info_d[0].code = sq_info_q[SQN].code;
    dv_info_d[0].neg1 = n1[NNW-1];
    dv_info_d[0].neg2 = n2[NNW-1];
    dv_info_d[0].d    = (sq_info_q[SQN].d == '0) ? (W+1)'(1) : sq_info_q[SQN].d;
    dv_num_d[0][0] = n1[NNW-1] ? (frac ? NW'(~n1) : NW'(-n1)) : NW'(n1);
    dv_num_d[1][0] = n2[NNW-1] ? (frac ? NW'(~n2) : NW'(-n2)) : NW'(n2);
    dv_num_d[2][0] = is_cplx ? NW'(s_root) : '0;
    for (int l = 0; l < LANES; l++) begin
      dv_rem_d[l][0] = '0;
    end
    // One restoring quotient bit per stage, three lanes sharing the divisor.
    for (int j = 0; j < NW; j++) begin
      dv_info_d[j+1] = dv_info_q[j];
      for (int l = 0; l < LANES; l++) begin
        dv_sh[l][j] = {dv_rem_q[l][j][RDW-2:0], dv_num_q[l][j][NW-1]};
        if (dv_sh[l][j] >= RDW'(dv_info_q[j].d)) begin
          dv_rem_d[l][j+1] = dv_sh[l][j] - RDW'(dv_info_q[j].d);
          dv_num_d[l][j+1] = {dv_num_q[l][j][NW-2:0], 1'b1};
        end else begin
          dv_rem_d[l][j+1] = dv_sh[l][j];
          dv_num_d[l][j+1] = {dv_num_q[l][j][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j <= NW; j++) begin
        dv_info_q[j] <= dv_info_d[j];
        for (int l = 0; l < LANES; l++) begin
          dv_num_q[l][j] <= dv_num_d[l][j];
          dv_rem_q[l][j] <= dv_rem_d[l][j];
        end
      end
    end
  end

  // Output stage: apply the signs and saturate into the result fields.
  function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [NW-1:0] q,
                                                     input logic neg);
    logic [SW-1:0] qe;
    qe = SW'(q);
    if (neg) begin
      sat_root = (qe > SW'(ROOT_NEG_MAG)) ? ROOT_WIDTH'(-SW'(ROOT_NEG_MAG))
                                          : ROOT_WIDTH'(-qe);
    end else begin
      sat_root = (qe > SW'(ROOT_MAX)) ? ROOT_WIDTH'(SW'(ROOT_MAX)) : ROOT_WIDTH'(qe);
    end
  endfunction

  logic                          out_vld_q;
  case_e                         out_code_q;
  logic signed [ROOT_WIDTH-1:0]  out_r1_q, out_r2_q;
  logic [IMAG_WIDTH-1:0]         out_im_q;
  logic [SW-1:0]                 q3e;

  assign q3e = SW'(dv_num_q[2][NW]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_code_q <= dv_info_q[NW].code;
      out_r1_q   <= signed'(sat_root(dv_num_q[0][NW], dv_info_q[NW].neg1));
      out_r2_q   <= signed'(sat_root(dv_num_q[1][NW], dv_info_q[NW].neg2));
      out_im_q   <= (q3e > SW'(IMAG_MAX)) ? IMAG_WIDTH'(SW'(IMAG_MAX))
                                          : IMAG_WIDTH'(q3e);
    end
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= coef_i.valid;
      sq_vld_q  <= {sq_vld_q[SQN-1:0], s1_vld_q};
      dv_vld_q  <= {dv_vld_q[NW-1:0], sq_vld_q[SQN]};
      out_vld_q <= dv_vld_q[NW];
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.case_code = out_code_q;
  assign res_o.root_one  = out_r1_q;
  assign res_o.root_two  = out_r2_q;
  assign res_o.imag_part = out_im_q;

`ifndef SYNTHESIS
  // Only two distinct real roots use the second root field.
  a_root_two_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.case_code != CASE_TWO_REAL) |-> res_o.root_two == '0)
    else $error("root_two nonzero outside the two real roots case");

  // Only a complex pair carries an imaginary magnitude.
  a_imag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.case_code != CASE_COMPLEX) |-> res_o.imag_part == '0)
    else $error("imag_part nonzero outside the complex case");

  // A degenerate equation yields no root value.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.case_code == CASE_DEGEN) |-> res_o.root_one == '0)
    else $error("root_one nonzero for a degenerate equation");

  // A stalled output freezes the pipeline, so nothing new is taken in.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !coef_i.ready)
    else $error("input accepted while the output is stalled");
`endif

endmodule

// ===== bench/tb_integer_quadratic_root_solver.sv =====
// Self-checking bench for the integer quadratic root solver top level.
// Depends on iqrs_pkg and the channel interfaces in iqrs_if.sv.
module tb_integer_quadratic_root_solver;
  timeunit 1ns;
  timeprecision 1ps;
  import iqrs_pkg::*;

  // One coefficient set as offered to the solver.
  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } coef_word_t;

  // One solved result word.
  typedef struct packed {
    case_e              code;
    logic signed [16:0] r1;
    logic signed [16:0] r2;
    logic [15:0]        im;
  } root_word_t;

  logic clk_i;
  logic rst_ni;

  iqrs_coef_if #(.COEF_WIDTH(16)) coef_ch ();
  iqrs_root_if                    root_ch ();

  integer_quadratic_root_solver #(.COEF_WIDTH(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_ch.sink),
    .res_o  (root_ch.source)
  );

  coef_word_t pending_coefs[$];
  root_word_t expected_roots[$];
  int         error_count;
  bit         hold_sink;   // Set by the long sink hold-off process.
  bit         pause_src;   // Set while the source waits for the pipe to drain.

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Integer square root, floor, by the bitwise method.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  // Floor of (p + k*sqrt(D)) / d, with s the floor root of D.
  function automatic longint floor_root(longint p, int k, longint s, bit exact, longint d);
    if (k > 0) return floor_quot(p + s, d);
    return floor_quot(p - s - (exact ? 0 : 1), d);
  endfunction

  // Truncation toward zero of the same irrational quotient.
  function automatic longint trunc_root(longint p, int k, longint s, bit exact, longint d);
    longint f;
    f = floor_root(p, k, s, exact, d);
    if (f >= 0) return f;
    return -floor_root(-p, -k, s, exact, d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Solves one coefficient set exactly as the hardware should.
  function automatic root_word_t solve_quadratic(coef_word_t w);
    root_word_t r;
    longint a, b, c, disc, p, d, s, r1, r2, im;
    bit exact;
    int k;
    a = w.a;
    b = w.b;
    c = w.c;
    r1 = 0;
    r2 = 0;
    im = 0;
    if (a == 0 && b == 0) begin
      r.code = CASE_DEGEN;
    end else if (a == 0) begin
      r.code = CASE_LINEAR;
      r1 = (-c) / b;
    end else begin
      disc = b * b - 4 * a * c;
      p = -b;
      d = 2 * a;
      if (d < 0) begin
        p = -p;
        d = -d;
      end
      if (disc > 0) begin
        s = int_sqrt(disc);
        exact = (s * s == disc);
        k = (a > 0) ? 1 : -1;
        r.code = CASE_TWO_REAL;
        r1 = trunc_root(p, k, s, exact, d);
        r2 = trunc_root(p, -k, s, exact, d);
      end else if (disc == 0) begin
        r.code = CASE_DOUBLE;
        r1 = p / d;
      end else begin
        s = int_sqrt(-disc);
        r.code = CASE_COMPLEX;
        r1 = p / d;
        im = s / d;
      end
    end
    r.r1 = 17'(clamp(r1, -ROOT_NEG_MAG, ROOT_MAX));
    r.r2 = 17'(clamp(r2, -ROOT_NEG_MAG, ROOT_MAX));
    r.im = 16'(clamp(im, 0, IMAG_MAX));
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'(int'($urandom_range(0, 6)) - 3);
      4: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Set at the rising edge at which the offered word is taken.
  bit src_accepted;

  // Driver: offers the next pending word after a random gap.
  int src_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_ch.valid      <= 1'b0;
      coef_ch.coef_quad  <= '0;
      coef_ch.coef_lin   <= '0;
      coef_ch.coef_const <= '0;
      src_gap <= 0;
    end else if (coef_ch.valid && !src_accepted) begin
      // Word still on offer; hold it.
    end else if (src_gap > 0) begin
      coef_ch.valid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_coefs.size() > 0 && !pause_src) begin
      coef_ch.valid      <= 1'b1;
      coef_ch.coef_quad  <= pending_coefs[0].a;
      coef_ch.coef_lin   <= pending_coefs[0].b;
      coef_ch.coef_const <= pending_coefs[0].c;
      void'(pending_coefs.pop_front());
      src_gap <= gap_len();
    end else begin
      coef_ch.valid <= 1'b0;
    end
  end

  // Records acceptance at the rising edge and predicts its result.
  always @(posedge clk_i) begin
    coef_word_t w;
    src_accepted <= 1'b0;
    if (rst_ni && coef_ch.valid && coef_ch.ready) begin
      w.a = coef_ch.coef_quad;
      w.b = coef_ch.coef_lin;
      w.c = coef_ch.coef_const;
      expected_roots.push_back(solve_quadratic(w));
      src_accepted <= 1'b1;
    end
  end

  // Sink ready with random stalls, overridden by the long hold-off.
  int sink_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_sink) begin
      root_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      root_ch.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      root_ch.ready <= 1'b1;
      sink_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  // The sink holds off for a long stretch right after reset while the source
  // keeps offering, so the pipeline fills and stalls its input.
  initial begin
    hold_sink = 1'b0;
    @(posedge rst_ni);
    hold_sink = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    root_word_t exp_w;
    if (rst_ni && root_ch.valid && root_ch.ready) begin
      if (expected_roots.size() == 0) begin
        $error("result word with no prediction waiting");
        error_count++;
      end else begin
        exp_w = expected_roots.pop_front();
        if (root_ch.case_code !== exp_w.code) begin
          $error("case_code expected %0d actual %0d", exp_w.code, root_ch.case_code);
          error_count++;
        end
        if (root_ch.root_one !== exp_w.r1) begin
          $error("root_one expected %0d actual %0d", exp_w.r1, root_ch.root_one);
          error_count++;
        end
        if (root_ch.root_two !== exp_w.r2) begin
          $error("root_two expected %0d actual %0d", exp_w.r2, root_ch.root_two);
          error_count++;
        end
        if (root_ch.imag_part !== exp_w.im) begin
          $error("imag_part expected %0d actual %0d", exp_w.im, root_ch.imag_part);
          error_count++;
        end
      end
    end
  end

  function automatic coef_word_t mk(int a, int b, int c);
    coef_word_t w;
    w.a = 16'(a);
    w.b = 16'(b);
    w.c = 16'(c);
    return w;
  endfunction

  // Waits until the driver has used up the queue and every result is back.
  task automatic drain_all();
    while (pending_coefs.size() > 0 || coef_ch.valid || expected_roots.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    coef_word_t w;
    error_count = 0;
    pause_src = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: each case, degenerate, extremes and irrational roots.
    pending_coefs.push_back(mk(0, 0, 0));
    pending_coefs.push_back(mk(0, 0, 32767));
    pending_coefs.push_back(mk(0, 3, 7));
    pending_coefs.push_back(mk(0, -3, 7));
    pending_coefs.push_back(mk(0, 1, -32768));
    pending_coefs.push_back(mk(0, -1, -32768));
    pending_coefs.push_back(mk(1, -3, 2));
    pending_coefs.push_back(mk(1, 0, -2));
    pending_coefs.push_back(mk(-1, 0, 2));
    pending_coefs.push_back(mk(1, 2, 1));
    pending_coefs.push_back(mk(-4, 4, -1));
    pending_coefs.push_back(mk(1, 1, 1));
    pending_coefs.push_back(mk(-3, 5, -7));
    pending_coefs.push_back(mk(1, -32768, -32768));
    pending_coefs.push_back(mk(1, 32767, 32767));
    pending_coefs.push_back(mk(-32768, -32768, -32768));
    pending_coefs.push_back(mk(32767, 32767, 32767));
    pending_coefs.push_back(mk(-32768, 32767, 32767));
    pending_coefs.push_back(mk(32767, -32768, -32768));
    pending_coefs.push_back(mk(1, 0, 32767));
    pending_coefs.push_back(mk(-1, -1, 0));
    pending_coefs.push_back(mk(-1, 0, 0));

    // Random words offered while the sink is held off.
    for (int i = 0; i < 200; i++) begin
      w.a = pick_coef();
      w.b = pick_coef();
      w.c = pick_coef();
      pending_coefs.push_back(w);
    end
    drain_all();

    // Part way through, the source pauses until every result has come back.
    for (int i = 0; i < 1330; i++) begin
      w.a = pick_coef();
      w.b = pick_coef();
      w.c = pick_coef();
      pending_coefs.push_back(w);
    end
    repeat (2000) @(posedge clk_i);
    pause_src = 1;
    while (expected_roots.size() > 0 || coef_ch.valid) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    pause_src = 0;
    drain_all();
    repeat (60) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[integer_quadratic_root_solver] OK");
    end else begin
      $display("[integer_quadratic_root_solver] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[integer_quadratic_root_solver] ERROR");
    $finish;
  end

endmodule
